### rtl/bfq8da_pkg.sv
// Shared types, character codes and positions for the fixed-point to ASCII formatter.
package bfq8da_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned Q_W       = 17;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned PROD_W    = 25;

  localparam logic [VALUE_W-1:0] FMT_LIMIT = 32'd256000;
  localparam logic [PROD_W-1:0]  SCALE     = 25'd100;
  localparam logic [Q_W-1:0]     Q_LIMIT   = 17'd100000;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_POINT = 8'h2E;
  localparam logic [7:0] ASCII_STAR  = 8'h2A;

  // Character positions in the seven-character field.
  localparam logic [2:0] POS_LEAD      = 3'd0;
  localparam logic [2:0] POS_HUND      = 3'd1;
  localparam logic [2:0] POS_TENS      = 3'd2;
  localparam logic [2:0] POS_ONES      = 3'd3;
  localparam logic [2:0] POS_POINT     = 3'd4;
  localparam logic [2:0] POS_TENTH     = 3'd5;
  localparam logic [2:0] POS_HUNDREDTH = 3'd6;

  // One classified word waiting for the back end.
  typedef struct packed {
    logic           ovf;
    logic [Q_W-1:0] q;
  } item_t;

endpackage

### rtl/bfq8da_ifs.sv
// Valid/ready channel interfaces for the input value and the output characters.
interface bfq8da_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface bfq8da_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

### rtl/bfq8da_front.sv
// Front end: accepts a value, flags overflow and scales it to hundredths.
module bfq8da_front (
  input  logic               clk,
  input  logic               rst,
  bfq8da_in_if.sink          in_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output bfq8da_pkg::item_t  push_item
);

  logic                                st_valid;
  bfq8da_pkg::item_t                   st_item;
  bfq8da_pkg::item_t                   item_next;
  logic [bfq8da_pkg::PROD_W-1:0]       prod;

  // Only the low 18 bits matter once the value is known to be below the limit.
  always_comb begin
    prod           = {7'd0, in_ch.value[17:0]} * bfq8da_pkg::SCALE;
    item_next.ovf  = (in_ch.value >= bfq8da_pkg::FMT_LIMIT);
    item_next.q    = prod[bfq8da_pkg::PROD_W-1:bfq8da_pkg::FRAC_BITS];
  end

  assign in_ch.ready = !st_valid || push_ready;
  assign push_valid  = st_valid;
  assign push_item   = st_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ch.ready) begin
      st_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      st_item <= item_next;
    end
  end

`ifndef SYNTH
  a_q_range: assert property (@(posedge clk) disable iff (rst)
    (st_valid && !st_item.ovf) |-> (st_item.q < bfq8da_pkg::Q_LIMIT))
    else $error("scaled value out of range");
`endif

endmodule

### rtl/bfq8da_queue.sv
// Small FIFO that decouples the front end from the character generator.
module bfq8da_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  bfq8da_pkg::item_t  push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output bfq8da_pkg::item_t  pop_item
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bfq8da_pkg::item_t entries [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CW'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CW'(1);
      end
    end
    if (push_fire) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");
  a_count_pop: assert property (@(posedge clk) disable iff (rst)
    (pop_fire && !push_fire) |=> (count == $past(count) - CW'(1)))
    else $error("queue count did not drop on pop");
`endif

endmodule

### rtl/bfq8da_back.sv
// Back end: peels decimal digits and drives one character per cycle while not stalled.
module bfq8da_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  bfq8da_pkg::item_t  pop_item,
  bfq8da_out_if.source       out_ch
);

  logic                         busy;
  logic [2:0]                   pos;
  logic                         ovf;
  logic                         blank;
  logic [bfq8da_pkg::Q_W-1:0]   rem;
  logic                         out_valid;
  logic [7:0]                   out_char;
  logic                         out_last;

  logic                         adv;
  logic                         at_last;
  logic [bfq8da_pkg::Q_W-1:0]   weight;
  logic                         takes_digit;
  logic [20:0]                  thr;
  logic [3:0]                   digit;
  logic [20:0]                  sub;
  logic [7:0]                   digit_char;
  logic [7:0]                   ch;
  logic                         blank_next;

  assign adv       = !out_valid || out_ch.ready;
  assign at_last   = (pos == bfq8da_pkg::POS_HUNDREDTH);
  assign pop_ready = adv && (!busy || at_last);

  // Place value of the digit that the current position shows.
  always_comb begin
    takes_digit = 1'b1;
    unique case (pos)
      bfq8da_pkg::POS_LEAD:  begin weight = 17'd10000; takes_digit = 1'b0; end
      bfq8da_pkg::POS_HUND:  weight = 17'd10000;
      bfq8da_pkg::POS_TENS:  weight = 17'd1000;
      bfq8da_pkg::POS_ONES:  weight = 17'd100;
      bfq8da_pkg::POS_POINT: begin weight = 17'd10; takes_digit = 1'b0; end
      bfq8da_pkg::POS_TENTH: weight = 17'd10;
      bfq8da_pkg::POS_HUNDREDTH: weight = 17'd1;
      default: begin weight = 17'd1; takes_digit = 1'b0; end
    endcase
  end

  // The remainder is below ten times the weight, so nine parallel compares find the digit.
  always_comb begin
    digit = 4'd0;
    sub   = 21'd0;
    for (int j = 1; j < 10; j++) begin
      thr = {4'd0, weight} * 21'(j);
      if ({4'd0, rem} >= thr) begin
        digit = 4'(j);
        sub   = thr;
      end
    end
    if (!takes_digit) begin
      sub = 21'd0;
    end
  end

  always_comb begin
    digit_char = bfq8da_pkg::ASCII_ZERO + {4'd0, digit};
    blank_next = blank;
    ch         = digit_char;
    if (ovf) begin
      if (pos == bfq8da_pkg::POS_LEAD) begin
        ch = bfq8da_pkg::ASCII_SPACE;
      end else if (pos == bfq8da_pkg::POS_POINT) begin
        ch = bfq8da_pkg::ASCII_POINT;
      end else begin
        ch = bfq8da_pkg::ASCII_STAR;
      end
    end else begin
      unique case (pos) inside
        bfq8da_pkg::POS_LEAD:  ch = bfq8da_pkg::ASCII_SPACE;
        bfq8da_pkg::POS_POINT: ch = bfq8da_pkg::ASCII_POINT;
        bfq8da_pkg::POS_HUND, bfq8da_pkg::POS_TENS: begin
          blank_next = blank && (digit == 4'd0);
          ch = blank_next ? bfq8da_pkg::ASCII_SPACE : digit_char;
        end
        default: ch = digit_char;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (pop_valid && pop_ready) begin
        busy <= 1'b1;
      end else if (adv && busy && at_last) begin
        busy <= 1'b0;
      end
    end
    if (adv && busy) begin
      out_char <= ch;
      out_last <= at_last;
    end
    if (pop_valid && pop_ready) begin
      pos   <= bfq8da_pkg::POS_LEAD;
      ovf   <= pop_item.ovf;
      rem   <= pop_item.q;
      blank <= 1'b1;
    end else if (adv && busy) begin
      rem   <= rem - sub[bfq8da_pkg::Q_W-1:0];
      blank <= blank_next;
      pos   <= pos + 3'd1;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.char_code = out_char;
  assign out_ch.last_char = out_last;

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos <= bfq8da_pkg::POS_HUNDREDTH))
    else $error("character position out of range");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (busy && !ovf) |-> ({4'd0, rem} < (21'd10 * {4'd0, weight})))
    else $error("remainder too large for current digit");
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (adv && busy && at_last) |=> (!busy || pos == bfq8da_pkg::POS_LEAD))
    else $error("field did not restart after the last character");
`endif

endmodule

### rtl/binary_fixed_q8_to_decimal_ascii_core.sv
// An accepted word passes the front-end register and the queue before the back end, which registers each character.
// Each word gives seven characters, one character per cycle on the output channel while it is not stalled.
// The front end takes a new word while the back end is still emitting the previous one.
// Reset (rst, synchronous): clears the valid flags, the queue pointers and count, and busy.
// Data registers and queue entries are not reset.
module binary_fixed_q8_to_decimal_ascii_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  bfq8da_in_if.sink     in_ch,
  bfq8da_out_if.source  out_ch
);

  logic               push_valid;
  logic               push_ready;
  bfq8da_pkg::item_t  push_item;
  logic               pop_valid;
  logic               pop_ready;
  bfq8da_pkg::item_t  pop_item;

  bfq8da_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  bfq8da_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  bfq8da_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule
